/* rtl/scpa_pkg.sv */
// shared types, constants and helpers for the size class pool allocator
`timescale 1ns / 1ps
package scpa_pkg;

  localparam int unsigned NUM_CLASSES = 7;
  localparam int unsigned CLS_W = 3;
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned SIZE_W = 32;
  localparam int unsigned IDX_W = 14;
  localparam int unsigned CNT_W = 15;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned DEF_SMALL_CLASS_ENTRIES = 16384;
  localparam int unsigned DEF_KIB_CLASS_ENTRIES = 1024;
  localparam int unsigned DEF_MIB_CLASS_ENTRIES = 2;
  localparam int unsigned DEF_FOUR_MIB_CLASS_ENTRIES = 4;
  localparam int unsigned DEF_SIXTEEN_MIB_CLASS_ENTRIES = 2;

  localparam int unsigned CLASS_SHIFT [NUM_CLASSES] = '{7, 8, 10, 12, 20, 22, 24};

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CLS_W-1:0] cls_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_OOM        = 3'd1,
    ST_TOO_LARGE  = 3'd2,
    ST_UNALIGNED  = 3'd3,
    ST_DOUBLE     = 3'd4,
    ST_ILLEGAL    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    K_ALLOC = 2'd0,
    K_FREE  = 2'd1,
    K_ERR   = 2'd2
  } kind_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    kind_t   kind;
    cls_t    cls;
    idx_t    idx;
    status_t err;
  } entry_t;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_FETCH = 2'd1,
    S_EXEC  = 2'd2
  } back_state_t;

  // block address offset inside its class region
  function automatic addr_t block_offset(input idx_t idx, input cls_t cls);
    addr_t wide;
    wide = ADDR_W'(idx);
    unique case (cls)
      3'd0: block_offset = wide << CLASS_SHIFT[0];
      3'd1: block_offset = wide << CLASS_SHIFT[1];
      3'd2: block_offset = wide << CLASS_SHIFT[2];
      3'd3: block_offset = wide << CLASS_SHIFT[3];
      3'd4: block_offset = wide << CLASS_SHIFT[4];
      3'd5: block_offset = wide << CLASS_SHIFT[5];
      3'd6: block_offset = wide << CLASS_SHIFT[6];
      default: block_offset = '0;
    endcase
  endfunction

  // block index of a region offset
  function automatic addr_t offset_index(input addr_t dif, input cls_t cls);
    unique case (cls)
      3'd0: offset_index = dif >> CLASS_SHIFT[0];
      3'd1: offset_index = dif >> CLASS_SHIFT[1];
      3'd2: offset_index = dif >> CLASS_SHIFT[2];
      3'd3: offset_index = dif >> CLASS_SHIFT[3];
      3'd4: offset_index = dif >> CLASS_SHIFT[4];
      3'd5: offset_index = dif >> CLASS_SHIFT[5];
      3'd6: offset_index = dif >> CLASS_SHIFT[6];
      default: offset_index = '0;
    endcase
  endfunction

  function automatic logic misaligned(input addr_t dif, input cls_t cls);
    addr_t mask;
    unique case (cls)
      3'd0: mask = (addr_t'(1) << CLASS_SHIFT[0]) - addr_t'(1);
      3'd1: mask = (addr_t'(1) << CLASS_SHIFT[1]) - addr_t'(1);
      3'd2: mask = (addr_t'(1) << CLASS_SHIFT[2]) - addr_t'(1);
      3'd3: mask = (addr_t'(1) << CLASS_SHIFT[3]) - addr_t'(1);
      3'd4: mask = (addr_t'(1) << CLASS_SHIFT[4]) - addr_t'(1);
      3'd5: mask = (addr_t'(1) << CLASS_SHIFT[5]) - addr_t'(1);
      3'd6: mask = (addr_t'(1) << CLASS_SHIFT[6]) - addr_t'(1);
      default: mask = '0;
    endcase
    misaligned = |(dif & mask);
  endfunction

endpackage

/* rtl/size_class_pool_allocator_top.sv */
// top level of the size class pool allocator
`timescale 1ns / 1ps
//  channel   | handshake          | data
//  request   | push / full        | command, request_size, free_address
//  result    | pop / empty        | granted_address, status
//  config    | cfg_write          | cfg_index, cfg_data
//
//  in the list engine each transaction passes S_FETCH for the link and used bit memory
//  read, then S_EXEC for the head, count and memory update; the front end registers
//  its classification ahead of a two-entry queue.
//  after reset a clearing pass rebuilds the free lists, one entry a cycle, over all
//  3*SMALL+KIB+MIB+FOUR_MIB+SIXTEEN_MIB entries (50184 by default); full stays high.
//  a result not popped holds the engine; the front end keeps filling the queue.
module size_class_pool_allocator_top #(
  parameter int unsigned SMALL_CLASS_ENTRIES = scpa_pkg::DEF_SMALL_CLASS_ENTRIES,
  parameter int unsigned KIB_CLASS_ENTRIES = scpa_pkg::DEF_KIB_CLASS_ENTRIES,
  parameter int unsigned MIB_CLASS_ENTRIES = scpa_pkg::DEF_MIB_CLASS_ENTRIES,
  parameter int unsigned FOUR_MIB_CLASS_ENTRIES = scpa_pkg::DEF_FOUR_MIB_CLASS_ENTRIES,
  parameter int unsigned SIXTEEN_MIB_CLASS_ENTRIES = scpa_pkg::DEF_SIXTEEN_MIB_CLASS_ENTRIES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic                               command,
  input  logic [scpa_pkg::SIZE_W-1:0]        request_size,
  input  logic [scpa_pkg::ADDR_W-1:0]        free_address,
  output logic                               empty,
  input  logic                               pop,
  output logic [scpa_pkg::ADDR_W-1:0]        granted_address,
  output logic [2:0]                         status,
  input  logic                               cfg_write,
  input  logic [scpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scpa_pkg::ADDR_W-1:0]        cfg_data
);
  import scpa_pkg::*;

  addr_t  base [NUM_CLASSES+1];
  logic   busy;
  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_valid;
  entry_t q_entry;
  entry_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NUM_CLASSES; i++) begin
        base[i] <= '0;
      end
    end else if (cfg_write) begin
      base[cfg_index] <= cfg_data;
    end
  end

  scpa_front #(
    .SMALL_CLASS_ENTRIES(SMALL_CLASS_ENTRIES),
    .KIB_CLASS_ENTRIES(KIB_CLASS_ENTRIES),
    .MIB_CLASS_ENTRIES(MIB_CLASS_ENTRIES),
    .FOUR_MIB_CLASS_ENTRIES(FOUR_MIB_CLASS_ENTRIES),
    .SIXTEEN_MIB_CLASS_ENTRIES(SIXTEEN_MIB_CLASS_ENTRIES)
  ) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .request_size(request_size), .free_address(free_address), .base(base),
    .busy(busy), .q_push(q_push), .q_entry(q_entry), .q_full(q_full)
  );

  scpa_queue u_queue (
    .clk(clk), .rst(rst), .q_push(q_push), .q_entry(q_entry), .q_full(q_full),
    .q_pop(q_pop), .q_valid(q_valid), .q_head(q_head)
  );

  scpa_back #(
    .SMALL_CLASS_ENTRIES(SMALL_CLASS_ENTRIES),
    .KIB_CLASS_ENTRIES(KIB_CLASS_ENTRIES),
    .MIB_CLASS_ENTRIES(MIB_CLASS_ENTRIES),
    .FOUR_MIB_CLASS_ENTRIES(FOUR_MIB_CLASS_ENTRIES),
    .SIXTEEN_MIB_CLASS_ENTRIES(SIXTEEN_MIB_CLASS_ENTRIES)
  ) u_back (
    .clk(clk), .rst(rst), .base(base), .q_valid(q_valid), .q_head(q_head),
    .q_pop(q_pop), .busy(busy), .empty(empty), .pop(pop),
    .granted_address(granted_address), .status(status)
  );

endmodule

/* rtl/scpa_front.sv */
// front end: classifies requests and checks free addresses
`timescale 1ns / 1ps
module scpa_front #(
  parameter int unsigned SMALL_CLASS_ENTRIES = scpa_pkg::DEF_SMALL_CLASS_ENTRIES,
  parameter int unsigned KIB_CLASS_ENTRIES = scpa_pkg::DEF_KIB_CLASS_ENTRIES,
  parameter int unsigned MIB_CLASS_ENTRIES = scpa_pkg::DEF_MIB_CLASS_ENTRIES,
  parameter int unsigned FOUR_MIB_CLASS_ENTRIES = scpa_pkg::DEF_FOUR_MIB_CLASS_ENTRIES,
  parameter int unsigned SIXTEEN_MIB_CLASS_ENTRIES = scpa_pkg::DEF_SIXTEEN_MIB_CLASS_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            command,
  input  logic [scpa_pkg::SIZE_W-1:0]     request_size,
  input  scpa_pkg::addr_t                 free_address,
  input  scpa_pkg::addr_t                 base [scpa_pkg::NUM_CLASSES+1],
  input  logic                            busy,
  output logic                            q_push,
  output scpa_pkg::entry_t                q_entry,
  input  logic                            q_full
);
  import scpa_pkg::*;

  localparam cnt_t ENT [NUM_CLASSES] = '{
    CNT_W'(SMALL_CLASS_ENTRIES), CNT_W'(SMALL_CLASS_ENTRIES), CNT_W'(KIB_CLASS_ENTRIES),
    CNT_W'(SMALL_CLASS_ENTRIES), CNT_W'(MIB_CLASS_ENTRIES), CNT_W'(FOUR_MIB_CLASS_ENTRIES),
    CNT_W'(SIXTEEN_MIB_CLASS_ENTRIES)
  };

  logic  st_valid;
  logic  st_cmd;
  logic  st_hit;
  cls_t  st_cls;
  addr_t st_addr;

  logic  accept;
  logic  in_hit;
  cls_t  in_cls;
  addr_t dif;
  addr_t idx_wide;

  assign full   = busy | (st_valid & q_full);
  assign accept = push & ~full;
  assign q_push = st_valid & ~q_full;

  // smallest fitting class, or first address range that holds the block
  always_comb begin
    in_hit = 1'b0;
    in_cls = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (!in_hit) begin
        if (command == CMD_ALLOC) begin
          if (33'(request_size) <= (33'(1) << CLASS_SHIFT[c])) begin
            in_hit = 1'b1;
            in_cls = CLS_W'(c);
          end
        end else if (free_address >= base[c] && free_address < base[c+1]) begin
          in_hit = 1'b1;
          in_cls = CLS_W'(c);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (accept) begin
      st_valid <= 1'b1;
    end else if (q_push) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_cmd  <= command;
      st_hit  <= in_hit;
      st_cls  <= in_cls;
      st_addr <= free_address;
    end
  end

  assign dif      = st_addr - base[st_cls];
  assign idx_wide = offset_index(dif, st_cls);

  always_comb begin
    q_entry      = '0;
    q_entry.cls  = st_cls;
    q_entry.kind = K_ERR;
    q_entry.err  = ST_OK;
    if (st_cmd == CMD_ALLOC) begin
      if (st_hit) begin
        q_entry.kind = K_ALLOC;
      end else begin
        q_entry.err = ST_TOO_LARGE;
      end
    end else if (!st_hit) begin
      q_entry.err = ST_ILLEGAL;
    end else if (misaligned(dif, st_cls)) begin
      q_entry.err = ST_UNALIGNED;
    end else if (idx_wide >= ADDR_W'(ENT[st_cls])) begin
      q_entry.err = ST_ILLEGAL;
    end else begin
      q_entry.kind = K_FREE;
      q_entry.idx  = idx_wide[IDX_W-1:0];
    end
  end

endmodule

/* rtl/scpa_queue.sv */
// short queue between the front end and the list engine
`timescale 1ns / 1ps
module scpa_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_push,
  input  scpa_pkg::entry_t  q_entry,
  output logic              q_full,
  input  logic              q_pop,
  output logic              q_valid,
  output scpa_pkg::entry_t  q_head
);
  import scpa_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  entry_t               slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [PTR_W:0]       fill;

  assign q_full  = (fill == (PTR_W+1)'(QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign q_head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (q_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (q_push && !q_pop) begin
        fill <= fill + (PTR_W+1)'(1);
      end else if (q_pop && !q_push) begin
        fill <= fill - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      slots[wr_ptr] <= q_entry;
    end
  end

endmodule

/* rtl/scpa_back.sv */
// list engine: free list memories, heads, counts and the result register
`timescale 1ns / 1ps
module scpa_back #(
  parameter int unsigned SMALL_CLASS_ENTRIES = scpa_pkg::DEF_SMALL_CLASS_ENTRIES,
  parameter int unsigned KIB_CLASS_ENTRIES = scpa_pkg::DEF_KIB_CLASS_ENTRIES,
  parameter int unsigned MIB_CLASS_ENTRIES = scpa_pkg::DEF_MIB_CLASS_ENTRIES,
  parameter int unsigned FOUR_MIB_CLASS_ENTRIES = scpa_pkg::DEF_FOUR_MIB_CLASS_ENTRIES,
  parameter int unsigned SIXTEEN_MIB_CLASS_ENTRIES = scpa_pkg::DEF_SIXTEEN_MIB_CLASS_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  scpa_pkg::addr_t   base [scpa_pkg::NUM_CLASSES+1],
  input  logic              q_valid,
  input  scpa_pkg::entry_t  q_head,
  output logic              q_pop,
  output logic              busy,
  output logic              empty,
  input  logic              pop,
  output scpa_pkg::addr_t   granted_address,
  output logic [2:0]        status
);
  import scpa_pkg::*;

  localparam int unsigned TOTAL = 3 * SMALL_CLASS_ENTRIES + KIB_CLASS_ENTRIES
                                  + MIB_CLASS_ENTRIES + FOUR_MIB_CLASS_ENTRIES
                                  + SIXTEEN_MIB_CLASS_ENTRIES;
  localparam int unsigned SLOT_W = $clog2(TOTAL);

  localparam cnt_t ENT [NUM_CLASSES] = '{
    CNT_W'(SMALL_CLASS_ENTRIES), CNT_W'(SMALL_CLASS_ENTRIES), CNT_W'(KIB_CLASS_ENTRIES),
    CNT_W'(SMALL_CLASS_ENTRIES), CNT_W'(MIB_CLASS_ENTRIES), CNT_W'(FOUR_MIB_CLASS_ENTRIES),
    CNT_W'(SIXTEEN_MIB_CLASS_ENTRIES)
  };
  localparam logic [SLOT_W-1:0] OFF [NUM_CLASSES] = '{
    SLOT_W'(0),
    SLOT_W'(SMALL_CLASS_ENTRIES),
    SLOT_W'(2 * SMALL_CLASS_ENTRIES),
    SLOT_W'(2 * SMALL_CLASS_ENTRIES + KIB_CLASS_ENTRIES),
    SLOT_W'(3 * SMALL_CLASS_ENTRIES + KIB_CLASS_ENTRIES),
    SLOT_W'(3 * SMALL_CLASS_ENTRIES + KIB_CLASS_ENTRIES + MIB_CLASS_ENTRIES),
    SLOT_W'(3 * SMALL_CLASS_ENTRIES + KIB_CLASS_ENTRIES + MIB_CLASS_ENTRIES
            + FOUR_MIB_CLASS_ENTRIES)
  };
  localparam cls_t LAST_CLS = CLS_W'(NUM_CLASSES - 1);

  back_state_t state;
  back_state_t state_next;

  idx_t  link_mem [TOTAL];
  logic  use_mem  [TOTAL];
  idx_t  link_rd;
  logic  use_rd;

  idx_t  head  [NUM_CLASSES];
  cnt_t  count [NUM_CLASSES];

  logic [SLOT_W-1:0] clr_slot;
  cls_t              clr_cls;
  idx_t              clr_idx;
  cnt_t              clr_idx_inc;
  logic              clr_class_end;
  logic              clr_done;

  logic              out_valid;
  logic              out_room;
  logic              exec_fire;
  logic              oom;
  idx_t              op_idx;
  logic [SLOT_W-1:0] rd_slot;

  logic              link_we;
  logic [SLOT_W-1:0] link_wa;
  idx_t              link_wd;
  logic              use_we;
  logic [SLOT_W-1:0] use_wa;
  logic              use_wd;
  logic              head_we;
  idx_t              head_wd;
  logic              cnt_inc;
  logic              cnt_dec;
  addr_t             res_addr;
  status_t           res_status;

  assign busy     = (state == S_CLEAR);
  assign empty    = ~out_valid;
  assign out_room = ~out_valid | pop;

  assign op_idx  = (q_head.kind == K_ALLOC) ? head[q_head.cls] : q_head.idx;
  assign rd_slot = OFF[q_head.cls] + SLOT_W'(op_idx);
  assign oom     = (count[q_head.cls] >= ENT[q_head.cls]);

  assign clr_idx_inc   = CNT_W'(clr_idx) + CNT_W'(1);
  assign clr_class_end = (clr_idx_inc == ENT[clr_cls]);
  assign clr_done      = clr_class_end && (clr_cls == LAST_CLS);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_done) state_next = S_FETCH;
      S_FETCH: if (q_valid) state_next = S_EXEC;
      S_EXEC:  if (out_room) state_next = S_FETCH;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    exec_fire  = 1'b0;
    link_we    = 1'b0;
    link_wa    = rd_slot;
    link_wd    = head[q_head.cls];
    use_we     = 1'b0;
    use_wa     = rd_slot;
    use_wd     = 1'b0;
    head_we    = 1'b0;
    head_wd    = link_rd;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    res_addr   = '0;
    res_status = q_head.err;
    unique case (state)
      S_CLEAR: begin
        // rebuild each class chain, last entry wraps to zero
        link_we = 1'b1;
        link_wa = clr_slot;
        link_wd = clr_class_end ? '0 : clr_idx_inc[IDX_W-1:0];
        use_we  = 1'b1;
        use_wa  = clr_slot;
        use_wd  = 1'b0;
      end
      S_FETCH: ;
      S_EXEC: begin
        exec_fire = out_room;
        unique case (q_head.kind)
          K_ALLOC: begin
            if (oom) begin
              res_status = ST_OOM;
            end else begin
              res_status = ST_OK;
              res_addr   = base[q_head.cls] + block_offset(op_idx, q_head.cls);
              use_we     = out_room;
              use_wd     = 1'b1;
              head_we    = out_room;
              head_wd    = link_rd;
              cnt_inc    = out_room;
            end
          end
          K_FREE: begin
            if (!use_rd) begin
              res_status = ST_DOUBLE;
            end else begin
              res_status = ST_OK;
              use_we     = out_room;
              use_wd     = 1'b0;
              link_we    = out_room;
              head_we    = out_room;
              head_wd    = q_head.idx;
              cnt_dec    = out_room && (count[q_head.cls] != '0);
            end
          end
          default: res_status = q_head.err;
        endcase
      end
      default: ;
    endcase
  end

  assign q_pop = exec_fire;

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd <= link_mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (use_we) begin
      use_mem[use_wa] <= use_wd;
    end
    use_rd <= use_mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_slot <= '0;
      clr_cls  <= '0;
      clr_idx  <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c]  <= '0;
        count[c] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_slot <= clr_slot + SLOT_W'(1);
        if (clr_class_end) begin
          clr_cls <= clr_cls + CLS_W'(1);
          clr_idx <= '0;
        end else begin
          clr_idx <= clr_idx_inc[IDX_W-1:0];
        end
      end
      if (head_we) begin
        head[q_head.cls] <= head_wd;
      end
      if (cnt_inc) begin
        count[q_head.cls] <= count[q_head.cls] + CNT_W'(1);
      end else if (cnt_dec) begin
        count[q_head.cls] <= count[q_head.cls] - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      granted_address <= res_addr;
      status          <= res_status;
    end
  end

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    busy |-> !q_pop) else $error("queue popped during clearing pass");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == S_EXEC) && q_valid) else $error("pop without queued entry");

  a_result_room: assert property (@(posedge clk) disable iff (rst)
    exec_fire |-> (!out_valid || pop)) else $error("result overwritten");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> out_valid && $stable(granted_address) && $stable(status))
    else $error("waiting result changed");

endmodule

/* test/tb_size_class_pool_allocator_top.sv */
// testbench for the size class pool allocator: random and directed requests against a predictor
`timescale 1ns / 1ps
module tb_size_class_pool_allocator_top;
  import scpa_pkg::*;

  localparam int unsigned SHIFT_OF [7] = '{7, 8, 10, 12, 20, 22, 24};
  localparam int unsigned ENTRIES_OF [7] = '{16384, 16384, 1024, 16384, 2, 4, 2};
  localparam int unsigned FIRST_OF [7] = '{0, 16384, 32768, 33792, 50176, 50178, 50182};
  localparam int unsigned TOTAL = 50184;
  localparam logic [2:0] REG_LIMIT = 3'd7;

  class pool_scoreboard;
    addr_t     base_addr [8];
    bit [15:0] link_mem [TOTAL];
    bit        busy_mem [TOTAL];
    bit [15:0] head_idx [7];
    int        used_cnt [7];
    addr_t     want_addr [$];
    status_t   want_status [$];
    int        mismatches;

    function void clear_state();
      for (int c = 0; c < 7; c++) begin
        head_idx[c] = 0;
        used_cnt[c] = 0;
        for (int i = 0; i < ENTRIES_OF[c]; i++) begin
          link_mem[FIRST_OF[c] + i] = (i + 1 < ENTRIES_OF[c]) ? 16'(i + 1) : 16'd0;
          busy_mem[FIRST_OF[c] + i] = 1'b0;
        end
      end
      for (int r = 0; r < 8; r++) base_addr[r] = '0;
      mismatches = 0;
    endfunction

    function void note_request(logic cmd, logic [31:0] sz, addr_t fa);
      int c;
      int unsigned idx;
      int unsigned slot;
      addr_t dif;
      addr_t wide_idx;
      if (cmd == CMD_ALLOC) begin
        c = 7;
        for (int k = 6; k >= 0; k--)
          if (64'(sz) <= (64'd1 << SHIFT_OF[k])) c = k;
        if (c == 7) begin
          want_addr.push_back('0); want_status.push_back(ST_TOO_LARGE); return;
        end
        if (used_cnt[c] >= ENTRIES_OF[c]) begin
          want_addr.push_back('0); want_status.push_back(ST_OOM); return;
        end
        idx = head_idx[c] % ENTRIES_OF[c];
        head_idx[c] = link_mem[FIRST_OF[c] + idx];
        used_cnt[c]++;
        busy_mem[FIRST_OF[c] + idx] = 1'b1;
        want_addr.push_back(base_addr[c] + (addr_t'(idx) << SHIFT_OF[c]));
        want_status.push_back(ST_OK);
        return;
      end
      c = 7;
      for (int k = 6; k >= 0; k--)
        if (fa >= base_addr[k] && fa < base_addr[k + 1]) c = k;
      want_addr.push_back('0);
      if (c == 7) begin
        want_status.push_back(ST_ILLEGAL); return;
      end
      dif = fa - base_addr[c];
      if ((dif & ((addr_t'(1) << SHIFT_OF[c]) - 1)) != 0) begin
        want_status.push_back(ST_UNALIGNED); return;
      end
      wide_idx = dif >> SHIFT_OF[c];
      if (wide_idx >= ENTRIES_OF[c]) begin
        want_status.push_back(ST_ILLEGAL); return;
      end
      slot = FIRST_OF[c] + int'(wide_idx);
      if (!busy_mem[slot]) begin
        want_status.push_back(ST_DOUBLE); return;
      end
      busy_mem[slot] = 1'b0;
      link_mem[slot] = head_idx[c];
      head_idx[c] = 16'(wide_idx);
      if (used_cnt[c] > 0) used_cnt[c]--;
      want_status.push_back(ST_OK);
    endfunction

    function void check_result(addr_t ga, logic [2:0] st);
      addr_t ea;
      status_t es;
      if (want_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result addr=%h status=%0d", ga, st);
        return;
      end
      ea = want_addr.pop_front();
      es = want_status.pop_front();
      if (ga !== ea || st !== es) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected addr=%h status=%0d, got addr=%h status=%0d",
                   ea, es, ga, st);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic command = 1'b0;
  logic [31:0] request_size = '0;
  addr_t free_address = '0;
  logic pop = 1'b0;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  addr_t cfg_data = '0;
  logic full, empty;
  addr_t granted_address;
  logic [2:0] status;

  pool_scoreboard sb;
  int idle_pct = 35;
  addr_t granted_pool [$];

  always #2 clk = ~clk;

  size_class_pool_allocator_top dut (.*);

  // result side: pop at random, check on each accepted transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        sb.check_result(granted_address, status);
        if (status == ST_OK && granted_address != '0) granted_pool.push_back(granted_address);
        else if (status == ST_OK && granted_address == '0) granted_pool.push_back('0);
      end
      pop <= ($urandom_range(99) >= idle_pct);
    end
  end

  // the task waits with the enable low after each write, which keeps it from being driven twice in a step
  task automatic write_reg(logic [2:0] idx, addr_t val);
    cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.base_addr[idx] = val;
    @(posedge clk);
  endtask

  // push stays high after acceptance until the next call or drain lowers it
  task automatic send_request(logic cmd, logic [31:0] sz, addr_t fa);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1; command <= cmd; request_size <= sz; free_address <= fa;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_request(cmd, sz, fa);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.want_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_bases(addr_t b0, addr_t step_small, addr_t b4);
    addr_t b [8];
    b[0] = b0;
    b[1] = b[0] + (addr_t'(16384) << 7);
    b[2] = b[1] + (addr_t'(16384) << 8);
    b[3] = b[2] + (addr_t'(1024) << 10);
    b[4] = b4;
    b[5] = b[4] + (addr_t'(2) << 20);
    b[6] = b[5] + (addr_t'(4) << 22);
    b[7] = b[6] + (addr_t'(2) << 24);
    if (step_small != 0) b[4] = b[3] + (addr_t'(16384) << 12);
    for (int r = 0; r < 8; r++) write_reg(3'(r), b[r]);
  endtask

  function automatic logic [31:0] pick_size();
    case ($urandom_range(9))
      0: return $urandom_range(128);
      1: return $urandom_range(256, 129);
      2: return $urandom_range(1024, 257);
      3: return $urandom_range(4096, 1025);
      4: return $urandom_range(1 << 20, 4097);
      5: return $urandom_range(4 << 20, (1 << 20) + 1);
      6: return $urandom_range(16 << 20, (4 << 20) + 1);
      7: return $urandom_range(32'hFFFF_FFFF, (16 << 20) + 1);
      default: return $urandom_range(300);
    endcase
  endfunction

  function automatic addr_t pick_free();
    addr_t a;
    int k;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        if (granted_pool.size() == 0) return {16'($urandom), 32'($urandom)};
        k = $urandom_range(granted_pool.size() - 1);
        a = granted_pool[k];
        if ($urandom_range(3) != 0) granted_pool.delete(k);
        return a;
      end
      6: return sb.base_addr[$urandom_range(6)] + addr_t'($urandom_range(8)) * 128;
      7: return sb.base_addr[$urandom_range(6)] + $urandom_range(127);
      default: return {16'($urandom), 32'($urandom)};
    endcase
  endfunction

  task automatic random_phase(int n, int alloc_pct);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) idle_pct = 0;
      if (i == n / 2 + n / 5) idle_pct = 35;
      if ($urandom_range(99) < alloc_pct) send_request(CMD_ALLOC, pick_size(), '0);
      else send_request(CMD_FREE, 32'h0, pick_free());
    end
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // phase 1: all bases at reset zero, every region empty
    send_request(CMD_ALLOC, 32'd0, '0);
    send_request(CMD_FREE, 32'd0, 48'h0);
    send_request(CMD_FREE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    drain();
    set_bases(48'h1000_0000, 1, '0);
    // directed: class boundaries, exhaustion, frees of each flavour
    send_request(CMD_ALLOC, 32'd0, '0);
    send_request(CMD_ALLOC, 32'd128, '0);
    send_request(CMD_ALLOC, 32'd129, '0);
    send_request(CMD_ALLOC, 32'd1024, '0);
    send_request(CMD_ALLOC, 32'd4096, '0);
    send_request(CMD_ALLOC, 32'd1 << 20, '0);
    send_request(CMD_ALLOC, 32'd1 << 20, '0);
    send_request(CMD_ALLOC, 32'd1 << 20, '0);
    send_request(CMD_ALLOC, 32'd4 << 20, '0);
    send_request(CMD_ALLOC, 32'd16 << 20, '0);
    send_request(CMD_ALLOC, 32'd16 << 20, '0);
    send_request(CMD_ALLOC, 32'd16 << 20, '0);
    send_request(CMD_ALLOC, (32'd16 << 20) + 1, '0);
    send_request(CMD_ALLOC, 32'hFFFF_FFFF, '0);
    send_request(CMD_FREE, 32'd0, 48'h1000_0000);
    send_request(CMD_FREE, 32'd0, 48'h1000_0000);
    send_request(CMD_FREE, 32'd0, 48'h1000_0001);
    send_request(CMD_FREE, 32'd0, 48'h0FFF_FFFF);
    send_request(CMD_FREE, 32'd0, sb.base_addr[7]);
    send_request(CMD_FREE, 32'd0, sb.base_addr[1] - 48'd128);
    drain();
    random_phase(300, 60);
    drain();
    // phase 3: wrapping region near the top of the address space
    granted_pool.delete();
    set_bases(48'hFFFF_FFF0_0000, 1, 48'h7FFF_FF00_0000);
    write_reg(REG_LIMIT, 48'hFFFF_FFFF_FFFF);
    random_phase(250, 55);
    drain();
    // phase 4: overlapping and empty ranges
    granted_pool.delete();
    for (int r = 0; r < 8; r++) write_reg(3'(r), {16'($urandom), 32'($urandom)});
    write_reg(3'd0, '0);
    random_phase(250, 50);
    drain();
    if (sb.mismatches == 0 && sb.want_status.size() == 0)
      $display("size_class_pool_allocator_top verification clean");
    else
      $display("size_class_pool_allocator_top verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("size_class_pool_allocator_top verification failed");
    $finish;
  end
endmodule

/* files.f */
rtl/scpa_pkg.sv
rtl/scpa_front.sv
rtl/scpa_queue.sv
rtl/scpa_back.sv
rtl/size_class_pool_allocator_top.sv
test/tb_size_class_pool_allocator_top.sv
